// ----- sv/qvp_pkg.sv -----
// Shared types, codes and constants of the quad vertex projection block.
`timescale 1ns / 1ps
package qvp_pkg;

  // Fraction bits of an input corner coordinate and of an internal point.
  localparam int unsigned COORD_FRAC_BITS = 8;
  localparam int unsigned PT_FRAC         = 16;
  localparam int unsigned PT_SHIFT        = PT_FRAC - COORD_FRAC_BITS;

  // Width of a matrix accumulator: three 32x16 products plus a shifted term.
  localparam int unsigned ACC_W = 49;

  // Largest quotient magnitude.
  localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;

  // Number of divider iterations (bits of quotient below the saturation limit).
  localparam int unsigned DIV_STEPS = 31;

  // Reset values of the configuration registers.
  localparam logic [11:0] CENTER_X_RST = 12'd512;
  localparam logic [11:0] CENTER_Y_RST = 12'd384;
  localparam logic [15:0] SCALE_RST    = 16'd4000;

  typedef enum logic [1:0] {
    CFG_CENTER_X = 2'd0,
    CFG_CENTER_Y = 2'd1,
    CFG_SCALE    = 2'd2
  } qvp_cfg_e;

  typedef enum logic {
    OP_VERTEX = 1'b0,
    OP_COEF   = 1'b1
  } qvp_op_e;

  typedef enum logic {
    MAT_CAMERA     = 1'b0,
    MAT_PROJECTION = 1'b1
  } qvp_mat_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MAC,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_SCR_MUL,
    ST_SCR_ADD,
    ST_CULL_M1,
    ST_CULL_M2,
    ST_CULL_CMP,
    ST_EMIT
  } qvp_state_e;

  // Input word.
  typedef struct packed {
    logic               kind;
    logic signed [15:0] coord_x;
    logic signed [15:0] coord_y;
    logic signed [15:0] coord_z;
    logic               matrix_select;
    logic        [3:0]  coef_index;
    logic signed [15:0] coef_value;
  } qvp_in_t;

  // Output word.
  typedef struct packed {
    logic signed [15:0] screen_x;
    logic signed [15:0] screen_y;
    logic        [1:0]  corner;
    logic               last;
  } qvp_out_t;

  // Classified command passed from the front to the back.
  typedef struct packed {
    qvp_op_e            op;
    logic signed [31:0] pt_x;
    logic signed [31:0] pt_y;
    logic signed [31:0] pt_z;
    qvp_mat_e           mat;
    logic        [3:0]  coef_index;
    logic signed [15:0] coef_value;
  } qvp_cmd_t;

  // Divider request and response.
  typedef struct packed {
    logic                    start;
    logic signed [ACC_W-1:0] num;
    logic signed [ACC_W-1:0] den;
  } qvp_div_req_t;

  typedef struct packed {
    logic               done;
    logic signed [31:0] quot;
  } qvp_div_rsp_t;

endpackage

// ----- sv/quad_vertex_project_cull.sv -----
// Top level of the quad vertex projection and backface cull block.
//
// Input channel (in_valid_i/in_ready_o/in_data_i): each word is either a quad
// corner (kind 0) or a matrix coefficient write (kind 1). A two-entry command
// queue takes words while the transform engine is busy.
// Output channel (out_valid_o/out_ready_i/out_data_o): four corner words per
// visible quad, corner 0 to 3, with last set on corner 3. Culled quads emit
// nothing. The configuration port writes the screen center and scale.
// A coefficient write is taken in the idle state; a corner occupies the engine
// until it is done. The single shared radix-2 divider performs five divides per
// corner (x, y, z after the camera matrix, x and y after projection), alongside
// two passes of the single 32x17 multiply-accumulate unit and the screen
// mapping. The fourth corner adds the cull test: two multiplies and a compare.
// Reset clears the matrices, loads the default center and scale and starts a
// new quad. When the receiver stalls, the engine holds in its emit phase and
// input words wait in the queue until it drains.
`timescale 1ns / 1ps
module quad_vertex_project_cull import qvp_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  qvp_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output qvp_out_t out_data_o
);

  logic         cmd_valid, cmd_ready;
  qvp_cmd_t     cmd;
  qvp_div_req_t div_req;
  qvp_div_rsp_t div_rsp;

  qvp_front #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .cmd_valid_o (cmd_valid),
    .cmd_ready_i (cmd_ready),
    .cmd_o       (cmd)
  );

  qvp_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  qvp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_valid_i (cmd_valid),
    .cmd_ready_o (cmd_ready),
    .cmd_i       (cmd),
    .div_req_o   (div_req),
    .div_rsp_i   (div_rsp),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ----- sv/qvp_front.sv -----
// Front end: accepts input words, classifies them and queues commands.
`timescale 1ns / 1ps
module qvp_front import qvp_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  qvp_in_t  in_data_i,
  output logic     cmd_valid_o,
  input  logic     cmd_ready_i,
  output qvp_cmd_t cmd_o
);

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  qvp_cmd_t             queue_q [QUEUE_DEPTH];
  logic     [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic     [CNT_W-1:0] count_q;
  qvp_cmd_t             cmd_new;
  logic                 push, pop;

  // Classify the word and bring the coordinates to the internal point format.
  always_comb begin
    cmd_new.op         = in_data_i.kind ? OP_COEF : OP_VERTEX;
    cmd_new.pt_x       = 32'(in_data_i.coord_x) <<< PT_SHIFT;
    cmd_new.pt_y       = 32'(in_data_i.coord_y) <<< PT_SHIFT;
    cmd_new.pt_z       = 32'(in_data_i.coord_z) <<< PT_SHIFT;
    cmd_new.mat        = in_data_i.matrix_select ? MAT_PROJECTION : MAT_CAMERA;
    cmd_new.coef_index = in_data_i.coef_index;
    cmd_new.coef_value = in_data_i.coef_value;
  end

  assign in_ready_o  = (count_q != CNT_W'(QUEUE_DEPTH));
  assign cmd_valid_o = (count_q != '0);
  assign cmd_o       = queue_q[rd_ptr_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = cmd_valid_o && cmd_ready_i;

  // Queue pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        count_q <= count_q + 1'b1;
      end else if (pop && !push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  // Queue storage.
  always_ff @(posedge clk_i) begin
    if (push) begin
      queue_q[wr_ptr_q] <= cmd_new;
    end
  end

endmodule

// ----- sv/qvp_div.sv -----
// Iterative signed fixed-point divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module qvp_div import qvp_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  qvp_div_req_t req_i,
  output qvp_div_rsp_t rsp_o
);

  logic                    busy_q, done_q, neg_q;
  logic [4:0]              cnt_q;
  logic [ACC_W:0]          rem_q;
  logic [DIV_STEPS-1:0]    sh_q, quo_q;
  logic [ACC_W-1:0]        ud_q;
  logic signed [31:0]      res_q;
  logic [ACC_W-1:0]        un, ud;
  logic                    neg, ovf;
  logic [ACC_W:0]          trial;
  logic                    ge;
  logic [DIV_STEPS-1:0]    quo_next;

  // Magnitudes and the saturation check on the integer part.
  always_comb begin
    un    = req_i.num[ACC_W-1] ? ACC_W'(-req_i.num) : ACC_W'(req_i.num);
    ud    = req_i.den[ACC_W-1] ? ACC_W'(-req_i.den) : ACC_W'(req_i.den);
    neg   = req_i.num[ACC_W-1] != req_i.den[ACC_W-1];
    ovf   = {15'd0, un} >= {ud, 15'd0};
    trial = {rem_q[ACC_W-1:0], sh_q[DIV_STEPS-1]};
    ge    = trial >= {1'b0, ud_q};
    quo_next = {quo_q[DIV_STEPS-2:0], ge};
  end

  // Control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == 5'd1) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end else if (req_i.start) begin
        if (req_i.den == '0 || ovf) begin
          done_q <= 1'b1;
        end else begin
          busy_q <= 1'b1;
          cnt_q  <= 5'(DIV_STEPS);
        end
      end
    end
  end

  // Datapath: restoring division of |num| * 2^16 by |den|.
  always_ff @(posedge clk_i) begin
    if (busy_q) begin
      rem_q <= ge ? trial - {1'b0, ud_q} : trial;
      sh_q  <= {sh_q[DIV_STEPS-2:0], 1'b0};
      quo_q <= quo_next;
      if (cnt_q == 5'd1) begin
        res_q <= neg_q ? -$signed({1'b0, quo_next}) : $signed({1'b0, quo_next});
      end
    end else if (req_i.start) begin
      neg_q <= neg;
      ud_q  <= ud;
      rem_q <= (ACC_W + 1)'(un >> 15);
      sh_q  <= {un[14:0], 16'd0};
      quo_q <= '0;
      if (req_i.den == '0) begin
        if (req_i.num == '0) begin
          res_q <= '0;
        end else begin
          res_q <= req_i.num[ACC_W-1] ? -Q_MAX : Q_MAX;
        end
      end else if (ovf) begin
        res_q <= neg ? -Q_MAX : Q_MAX;
      end
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = res_q;

endmodule

// ----- sv/qvp_back.sv -----
// Back end: matrix transforms, perspective divides, screen mapping and culling.
`timescale 1ns / 1ps
module qvp_back import qvp_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [1:0]   cfg_index_i,
  input  logic [15:0]  cfg_wdata_i,
  input  logic         cmd_valid_i,
  output logic         cmd_ready_o,
  input  qvp_cmd_t     cmd_i,
  output qvp_div_req_t div_req_o,
  input  qvp_div_rsp_t div_rsp_i,
  output logic         out_valid_o,
  input  logic         out_ready_i,
  output qvp_out_t     out_data_o
);

  qvp_state_e state_q, state_d;
  qvp_mat_e   mat_q;
  logic [4:0] k_q;
  logic [1:0] d_idx_q, cnt_q, e_q;
  logic       prod_vld_q;
  logic [3:0] prod_idx_q;

  logic signed [15:0]      cam_m_q [16];
  logic signed [15:0]      prj_m_q [16];
  logic        [11:0]      center_x_q, center_y_q;
  logic        [15:0]      scale_q;
  logic signed [ACC_W-1:0] acc_q [4];
  logic signed [31:0]      v_q [3];
  logic signed [ACC_W-1:0] prod_q, p1_q;
  logic signed [15:0]      sx_q [4];
  logic signed [15:0]      sy_q [4];

  logic signed [31:0]      mul_a;
  logic signed [16:0]      mul_b;
  logic signed [ACC_W-1:0] mul_p;
  logic        [3:0]       m_idx;
  logic signed [15:0]      m_coef;
  logic signed [31:0]      v_sel;
  logic signed [32:0]      scr_t;
  logic signed [33:0]      scr_sum;
  logic signed [15:0]      scr_val;
  logic signed [16:0]      ax, ay, bx, by;
  logic                    last_div;

  // Coefficient for MAC step k: row k[1:0], column k[3:2].
  assign m_idx  = {k_q[1:0], k_q[3:2]};
  assign m_coef = (mat_q == MAT_PROJECTION) ? prj_m_q[m_idx] : cam_m_q[m_idx];

  always_comb begin
    case (k_q[1:0])
      2'd0:    v_sel = v_q[0];
      2'd1:    v_sel = v_q[1];
      2'd2:    v_sel = v_q[2];
      default: v_sel = 32'sh0001_0000;
    endcase
  end

  // Cull edges from the stored screen corners.
  assign ax = 17'(sx_q[1]) - 17'(sx_q[0]);
  assign ay = 17'(sy_q[1]) - 17'(sy_q[0]);
  assign bx = 17'(sx_q[0]) - 17'(sx_q[3]);
  assign by = 17'(sy_q[0]) - 17'(sy_q[3]);

  // Shared multiplier operand selection.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      ST_MAC: begin
        mul_a = v_sel;
        mul_b = 17'(m_coef);
      end
      ST_SCR_MUL: begin
        mul_a = d_idx_q[0] ? v_q[1] : v_q[0];
        mul_b = $signed({1'b0, scale_q});
      end
      ST_CULL_M1: begin
        mul_a = 32'(ax);
        mul_b = by;
      end
      ST_CULL_M2: begin
        mul_a = 32'(ay);
        mul_b = bx;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end
  assign mul_p = mul_a * mul_b;

  // Screen value: truncate toward zero, add the center, saturate.
  always_comb begin
    scr_t = 33'(prod_q >>> PT_FRAC);
    if (prod_q[ACC_W-1] && (prod_q[PT_FRAC-1:0] != '0)) begin
      scr_t = scr_t + 33'sd1;
    end
    scr_sum = 34'(scr_t) + $signed({22'd0, (d_idx_q[0] ? center_y_q : center_x_q)});
    if (scr_sum > 34'sd32767) begin
      scr_val = 16'sh7FFF;
    end else if (scr_sum < -34'sd32768) begin
      scr_val = -16'sh8000;
    end else begin
      scr_val = 16'(scr_sum);
    end
  end

  assign last_div = (mat_q == MAT_PROJECTION) ? (d_idx_q == 2'd1) : (d_idx_q == 2'd2);

  // Next state and handshake outputs.
  always_comb begin
    state_d     = state_q;
    cmd_ready_o = 1'b0;
    out_valid_o = 1'b0;
    div_req_o.start = 1'b0;
    div_req_o.num   = acc_q[d_idx_q];
    div_req_o.den   = acc_q[3];
    case (state_q)
      ST_IDLE: begin
        cmd_ready_o = 1'b1;
        if (cmd_valid_i && cmd_i.op == OP_VERTEX) begin
          state_d = ST_MAC;
        end
      end
      ST_MAC: begin
        if (k_q == 5'd16) begin
          state_d = ST_DIV_GO;
        end
      end
      ST_DIV_GO: begin
        div_req_o.start = 1'b1;
        state_d = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (div_rsp_i.done) begin
          if (!last_div) begin
            state_d = ST_DIV_GO;
          end else if (mat_q == MAT_CAMERA) begin
            state_d = ST_MAC;
          end else begin
            state_d = ST_SCR_MUL;
          end
        end
      end
      ST_SCR_MUL: state_d = ST_SCR_ADD;
      ST_SCR_ADD: begin
        if (!d_idx_q[0]) begin
          state_d = ST_SCR_MUL;
        end else if (cnt_q == 2'd3) begin
          state_d = ST_CULL_M1;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_CULL_M1: state_d = ST_CULL_M2;
      ST_CULL_M2: state_d = ST_CULL_CMP;
      ST_CULL_CMP: begin
        state_d = (p1_q > prod_q) ? ST_IDLE : ST_EMIT;
      end
      ST_EMIT: begin
        out_valid_o = 1'b1;
        if (out_ready_i && e_q == 2'd3) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign out_data_o.screen_x = sx_q[e_q];
  assign out_data_o.screen_y = sy_q[e_q];
  assign out_data_o.corner   = e_q;
  assign out_data_o.last     = (e_q == 2'd3);

  // State register, sequencing counters, matrices and configuration.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      mat_q      <= MAT_CAMERA;
      k_q        <= '0;
      d_idx_q    <= '0;
      cnt_q      <= '0;
      e_q        <= '0;
      prod_vld_q <= 1'b0;
      prod_idx_q <= '0;
      center_x_q <= CENTER_X_RST;
      center_y_q <= CENTER_Y_RST;
      scale_q    <= SCALE_RST;
      for (int i = 0; i < 16; i++) begin
        cam_m_q[i] <= '0;
        prj_m_q[i] <= '0;
      end
    end else begin
      state_q    <= state_d;
      prod_vld_q <= 1'b0;
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_CENTER_X: center_x_q <= cfg_wdata_i[11:0];
          CFG_CENTER_Y: center_y_q <= cfg_wdata_i[11:0];
          CFG_SCALE:    scale_q    <= cfg_wdata_i;
          default: ;
        endcase
      end
      case (state_q)
        ST_IDLE: begin
          if (cmd_valid_i) begin
            if (cmd_i.op == OP_COEF) begin
              if (cmd_i.mat == MAT_PROJECTION) begin
                prj_m_q[cmd_i.coef_index] <= cmd_i.coef_value;
              end else begin
                cam_m_q[cmd_i.coef_index] <= cmd_i.coef_value;
              end
            end else begin
              mat_q <= MAT_CAMERA;
              k_q   <= '0;
            end
          end
        end
        ST_MAC: begin
          if (k_q != 5'd16) begin
            prod_vld_q <= 1'b1;
            prod_idx_q <= k_q[3:0];
            k_q        <= k_q + 1'b1;
          end
          d_idx_q <= '0;
        end
        ST_DIV_WAIT: begin
          if (div_rsp_i.done) begin
            if (!last_div) begin
              d_idx_q <= d_idx_q + 1'b1;
            end else if (mat_q == MAT_CAMERA) begin
              mat_q <= MAT_PROJECTION;
              k_q   <= '0;
            end else begin
              d_idx_q <= '0;
            end
          end
        end
        ST_SCR_ADD: begin
          if (!d_idx_q[0]) begin
            d_idx_q <= 2'd1;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        ST_CULL_CMP: e_q <= '0;
        ST_EMIT: begin
          if (out_ready_i) begin
            e_q <= e_q + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    prod_q <= mul_p;
    if (prod_vld_q) begin
      if (prod_idx_q[1:0] == 2'd0) begin
        acc_q[prod_idx_q[3:2]] <= prod_q;
      end else begin
        acc_q[prod_idx_q[3:2]] <= acc_q[prod_idx_q[3:2]] + prod_q;
      end
    end
    if (state_q == ST_IDLE && cmd_valid_i && cmd_i.op == OP_VERTEX) begin
      v_q[0] <= cmd_i.pt_x;
      v_q[1] <= cmd_i.pt_y;
      v_q[2] <= cmd_i.pt_z;
    end
    if (state_q == ST_DIV_WAIT && div_rsp_i.done) begin
      case (d_idx_q)
        2'd0:    v_q[0] <= div_rsp_i.quot;
        2'd1:    v_q[1] <= div_rsp_i.quot;
        default: v_q[2] <= div_rsp_i.quot;
      endcase
    end
    if (state_q == ST_SCR_ADD) begin
      if (d_idx_q[0]) begin
        sy_q[cnt_q] <= scr_val;
      end else begin
        sx_q[cnt_q] <= scr_val;
      end
    end
    if (state_q == ST_CULL_M2) begin
      p1_q <= prod_q;
    end
  end

endmodule

// ----- sv/qvp_checker.sv -----
// Port-level checks of the output word sequence, bound to the top level.
`timescale 1ns / 1ps
module qvp_checker import qvp_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input qvp_out_t    out_data_o
);

  // A stalled output word holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("output word changed while stalled");

  // A quad always starts at corner 0.
  a_first_corner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> out_data_o.corner == 2'd0)
    else $error("quad did not start at corner 0");

  // The four corners of a quad follow without a gap.
  a_no_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !out_data_o.last |=> out_valid_o)
    else $error("gap inside a quad");

  // Corners count up by one after each taken word.
  a_corner_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !out_data_o.last
      |=> out_data_o.corner == $past(out_data_o.corner) + 2'd1)
    else $error("corner index did not advance");

endmodule

bind quad_vertex_project_cull qvp_checker u_qvp_checker (.*);
